@@ hw/rtl/bmom_pkg.sv @@
// shared types, constants and codes for the one-mismatch barcode matcher
package bmom_pkg;

    localparam int TABLE_DEPTH    = 64;
    localparam int BARCODE_LENGTH = 8;
    localparam int LANES          = 4;
    localparam int ROWS           = TABLE_DEPTH / LANES;
    localparam int LANE_BITS      = $clog2(LANES);
    localparam int ROW_BITS       = $clog2(ROWS);
    localparam int SHIFTS         = 3;

    localparam int NIB_W   = 4;
    localparam int QUAL_W  = 7;
    localparam int CODE_W  = 32;
    localparam int WIN_W   = 40;
    localparam int QUALS_W = 56;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;

    // shift slots, in priority order for the result
    localparam int SH_ZERO  = 0;
    localparam int SH_MINUS = 1;
    localparam int SH_PLUS  = 2;

    localparam logic [1:0] OFS_ZERO  = 2'b00;
    localparam logic [1:0] OFS_MINUS = 2'b11;
    localparam logic [1:0] OFS_PLUS  = 2'b01;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    localparam logic [1:0] ST_MATCH   = 2'd0;
    localparam logic [1:0] ST_LOWQ    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_LOADED  = 2'd3;

    localparam logic [CNT_W-1:0] MIN_QUAL_RESET = 7'd20;
    localparam logic [CNT_W-1:0] COUNT_RESET    = 7'd1;

    localparam logic ADDR_MIN_QUAL = 1'b0;
    localparam logic ADDR_COUNT    = 1'b1;

    typedef struct packed {
        logic                clear;
        logic                update;
        logic [ROW_BITS-1:0] row;
        logic [LANES-1:0]    lane_valid;
    } scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
        logic [1:0]       offset;
    } match_res_t;

endpackage

@@ hw/rtl/bmom_ram.sv @@
// generic single-write, single-read ram with registered read data
module bmom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bmom_lane.sv @@
// one compare lane: tests a table entry against the window at all three shifts
module bmom_lane (
    input  logic [bmom_pkg::CODE_W-1:0] entry_code,
    input  logic [bmom_pkg::WIN_W-1:0]  window,
    output logic [bmom_pkg::SHIFTS-1:0] hits
);

    logic [bmom_pkg::BARCODE_LENGTH-1:0] miss_zero;
    logic [bmom_pkg::BARCODE_LENGTH-1:0] miss_minus;
    logic [bmom_pkg::BARCODE_LENGTH-1:0] miss_plus;

    always_comb
    begin
        for (int k = 0; k < bmom_pkg::BARCODE_LENGTH; k++)
        begin
            miss_zero[k]  = entry_code[k*bmom_pkg::NIB_W +: bmom_pkg::NIB_W]
                            != window[(k+1)*bmom_pkg::NIB_W +: bmom_pkg::NIB_W];
            miss_minus[k] = entry_code[k*bmom_pkg::NIB_W +: bmom_pkg::NIB_W]
                            != window[k*bmom_pkg::NIB_W +: bmom_pkg::NIB_W];
            miss_plus[k]  = entry_code[k*bmom_pkg::NIB_W +: bmom_pkg::NIB_W]
                            != window[(k+2)*bmom_pkg::NIB_W +: bmom_pkg::NIB_W];
        end
    end

    // at most one bit set: clearing the lowest set bit leaves nothing
    assign hits[bmom_pkg::SH_ZERO]  = (miss_zero  & (miss_zero  - 1'b1)) == '0;
    assign hits[bmom_pkg::SH_MINUS] = (miss_minus & (miss_minus - 1'b1)) == '0;
    assign hits[bmom_pkg::SH_PLUS]  = (miss_plus  & (miss_plus  - 1'b1)) == '0;

endmodule

@@ hw/rtl/bmom_merge.sv @@
// merges lane hits row by row, keeping the first hit per shift
module bmom_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bmom_pkg::scan_ctl_t                    ctl,
    input  logic [bmom_pkg::LANES-1:0][bmom_pkg::SHIFTS-1:0] lane_hits,
    output bmom_pkg::match_res_t                   result
);

    logic [bmom_pkg::SHIFTS-1:0]                    found_reg;
    logic [bmom_pkg::SHIFTS-1:0]                    found_next;
    logic [bmom_pkg::SHIFTS-1:0][bmom_pkg::IDX_W-1:0] idx_reg;
    logic [bmom_pkg::SHIFTS-1:0][bmom_pkg::IDX_W-1:0] idx_next;
    logic [bmom_pkg::SHIFTS-1:0]                    row_hit;
    logic [bmom_pkg::SHIFTS-1:0][bmom_pkg::LANE_BITS-1:0] first_lane;

    // lowest lane with a hit, per shift
    always_comb
    begin
        for (int s = 0; s < bmom_pkg::SHIFTS; s++)
        begin
            row_hit[s]    = 1'b0;
            first_lane[s] = '0;
            for (int l = bmom_pkg::LANES - 1; l >= 0; l--)
            begin
                if (lane_hits[l][s] && ctl.lane_valid[l])
                begin
                    row_hit[s]    = 1'b1;
                    first_lane[s] = bmom_pkg::LANE_BITS'(l);
                end
            end
        end
    end

    always_comb
    begin
        found_next = found_reg;
        idx_next   = idx_reg;
        if (ctl.clear)
        begin
            found_next = '0;
            idx_next   = '0;
        end
        else if (ctl.update)
        begin
            for (int s = 0; s < bmom_pkg::SHIFTS; s++)
            begin
                if (!found_reg[s] && row_hit[s])
                begin
                    found_next[s] = 1'b1;
                    idx_next[s]   = bmom_pkg::IDX_W'({ctl.row, first_lane[s]});
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    always_comb
    begin
        result.found  = 1'b0;
        result.index  = '0;
        result.offset = bmom_pkg::OFS_ZERO;
        if (found_reg[bmom_pkg::SH_ZERO])
        begin
            result.found  = 1'b1;
            result.index  = idx_reg[bmom_pkg::SH_ZERO];
            result.offset = bmom_pkg::OFS_ZERO;
        end
        else if (found_reg[bmom_pkg::SH_MINUS])
        begin
            result.found  = 1'b1;
            result.index  = idx_reg[bmom_pkg::SH_MINUS];
            result.offset = bmom_pkg::OFS_MINUS;
        end
        else if (found_reg[bmom_pkg::SH_PLUS])
        begin
            result.found  = 1'b1;
            result.index  = idx_reg[bmom_pkg::SH_PLUS];
            result.offset = bmom_pkg::OFS_PLUS;
        end
    end

endmodule

@@ hw/rtl/barcode_match_one_mismatch_unit.sv @@
// top level of the one-mismatch barcode matcher: control, table banks and result register
// flow: load and low-quality requests finish at once, via S_FINISH if the output is full;
// match requests scan n = barcode_count saturated to 64 entries, none when n is 0
// throughput: one request at a time; the table is read one row of four entries per cycle,
// set by the four ram banks and their single read port each
// reset: rst_n clears control, min_quality to 20 and barcode_count to 1; the table is
// not cleared and entries are undefined until loaded
module barcode_match_one_mismatch_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [bmom_pkg::IDX_W-1:0]    entry_index,
    input  logic [bmom_pkg::CODE_W-1:0]   entry_code,
    input  logic [bmom_pkg::WIN_W-1:0]    window_bases,
    input  logic [bmom_pkg::QUALS_W-1:0]  base_quals,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          match_found,
    output logic [bmom_pkg::IDX_W-1:0]    barcode_index,
    output logic signed [1:0]             match_offset,
    output logic [1:0]                    status,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [bmom_pkg::CNT_W-1:0] min_quality_reg;
    logic [bmom_pkg::CNT_W-1:0] barcode_count_reg;
    logic                       cfg_write;

    // request side
    logic in_acc;
    logic slot_free;
    logic low_qual;
    logic [bmom_pkg::WIN_W-1:0] window_reg;

    // scan control
    logic [bmom_pkg::CNT_W-1:0]    cnt_sat;
    logic [bmom_pkg::CNT_W-1:0]    cnt_m1;
    logic [bmom_pkg::ROW_BITS-1:0] last_row;
    logic [bmom_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [bmom_pkg::ROW_BITS-1:0] row_d_reg;
    logic                          rd_valid_reg;
    logic                          scan_rd;

    // lanes and merge
    logic [bmom_pkg::LANES-1:0][bmom_pkg::CODE_W-1:0] bank_rdata;
    logic [bmom_pkg::LANES-1:0][bmom_pkg::SHIFTS-1:0] lane_hits;
    logic [bmom_pkg::LANES-1:0]                       lane_valid;
    bmom_pkg::scan_ctl_t                              merge_ctl;
    bmom_pkg::match_res_t                             merge_res;

    // pending status for a result that waits for the output slot
    logic [1:0] pend_status_reg, pend_status_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic                       out_load;
    logic                       out_found_next;
    logic [bmom_pkg::IDX_W-1:0] out_index_next;
    logic [1:0]                 out_offset_next;
    logic [1:0]                 out_status_next;
    logic                       out_found_reg;
    logic [bmom_pkg::IDX_W-1:0] out_index_reg;
    logic [1:0]                 out_offset_reg;
    logic [1:0]                 out_status_reg;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_quality_reg   <= bmom_pkg::MIN_QUAL_RESET;
            barcode_count_reg <= bmom_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == bmom_pkg::ADDR_MIN_QUAL)
            begin
                min_quality_reg <= pwdata[bmom_pkg::CNT_W-1:0];
            end
            else
            begin
                barcode_count_reg <= pwdata[bmom_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bmom_pkg::ADDR_MIN_QUAL: prdata = {25'd0, min_quality_reg};
            bmom_pkg::ADDR_COUNT:    prdata = {25'd0, barcode_count_reg};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- request decode ----------------
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // any barcode base below the threshold rejects the read
    always_comb
    begin
        low_qual = 1'b0;
        for (int k = 0; k < bmom_pkg::BARCODE_LENGTH; k++)
        begin
            if (base_quals[k*bmom_pkg::QUAL_W +: bmom_pkg::QUAL_W] < min_quality_reg)
            begin
                low_qual = 1'b1;
            end
        end
    end

    // entries searched, saturated to the table depth
    assign cnt_sat  = (barcode_count_reg > bmom_pkg::CNT_W'(bmom_pkg::TABLE_DEPTH))
                      ? bmom_pkg::CNT_W'(bmom_pkg::TABLE_DEPTH) : barcode_count_reg;
    assign cnt_m1   = cnt_sat - 1'b1;
    assign last_row = cnt_m1[bmom_pkg::LANE_BITS +: bmom_pkg::ROW_BITS];

    // ---------------- control ----------------
    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        pend_status_next = pend_status_reg;
        out_load         = 1'b0;
        out_found_next   = 1'b0;
        out_index_next   = '0;
        out_offset_next  = bmom_pkg::OFS_ZERO;
        out_status_next  = bmom_pkg::ST_NOMATCH;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (command == bmom_pkg::CMD_LOAD || low_qual)
                    begin
                        // finished at once: straight to the result register if free
                        out_status_next = (command == bmom_pkg::CMD_LOAD)
                                          ? bmom_pkg::ST_LOADED : bmom_pkg::ST_LOWQ;
                        if (slot_free)
                        begin
                            out_load = 1'b1;
                        end
                        else
                        begin
                            pend_status_next = out_status_next;
                            state_next       = S_FINISH;
                        end
                    end
                    else if (cnt_sat == '0)
                    begin
                        pend_status_next = bmom_pkg::ST_NOMATCH;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        pend_status_next = bmom_pkg::ST_NOMATCH;
                        row_next         = '0;
                        state_next       = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (row_reg == last_row)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (merge_res.found)
                    begin
                        out_found_next  = 1'b1;
                        out_index_next  = merge_res.index;
                        out_offset_next = merge_res.offset;
                        out_status_next = bmom_pkg::ST_MATCH;
                    end
                    else
                    begin
                        out_status_next = pend_status_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        row_d_reg       <= row_reg;
        pend_status_reg <= pend_status_next;
        if (in_acc)
        begin
            window_reg <= window_bases;
        end
    end

    // ---------------- table banks and lanes ----------------
    // entry e sits in bank e mod 4, row e / 4
    assign scan_rd = (state_reg == S_SCAN);

    for (genvar l = 0; l < bmom_pkg::LANES; l++)
    begin : g_lane
        logic bank_we;

        assign bank_we = in_acc && (command == bmom_pkg::CMD_LOAD)
                         && (entry_index[bmom_pkg::LANE_BITS-1:0]
                             == bmom_pkg::LANE_BITS'(l));

        bmom_ram #(
            .WIDTH (bmom_pkg::CODE_W),
            .DEPTH (bmom_pkg::ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we),
            .waddr (entry_index[bmom_pkg::LANE_BITS +: bmom_pkg::ROW_BITS]),
            .wdata (entry_code),
            .re    (scan_rd),
            .raddr (row_reg),
            .rdata (bank_rdata[l])
        );

        bmom_lane u_lane (
            .entry_code (bank_rdata[l]),
            .window     (window_reg),
            .hits       (lane_hits[l])
        );

        // entries at or beyond the count take no part
        assign lane_valid[l] = {1'b0, row_d_reg, bmom_pkg::LANE_BITS'(l)} < cnt_sat;
    end

    assign merge_ctl.clear      = in_acc;
    assign merge_ctl.update     = rd_valid_reg;
    assign merge_ctl.row        = row_d_reg;
    assign merge_ctl.lane_valid = lane_valid;

    bmom_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (merge_ctl),
        .lane_hits (lane_hits),
        .result    (merge_res)
    );

    // ---------------- result register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg  <= out_found_next;
            out_index_reg  <= out_index_next;
            out_offset_reg <= out_offset_next;
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_found   = out_found_reg;
    assign barcode_index = out_index_reg;
    assign match_offset  = out_offset_reg;
    assign status        = out_status_reg;

endmodule
